### rtl/core/csp_pkg.sv
// Shared types, constants and helpers of the constraint checker.
`default_nettype none

package csp_pkg;

  // Table and store geometry
  localparam int unsigned MAX_CONSTRAINTS = 64;
  localparam int unsigned NUM_VARS        = 256;
  localparam int unsigned TBL_AW          = $clog2(MAX_CONSTRAINTS);
  localparam int unsigned VAR_AW          = $clog2(NUM_VARS);

  // Field widths
  localparam int unsigned VAR_W   = 8;
  localparam int unsigned REL_W   = 3;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned MODE_W  = 2;

  // Item kinds carried on tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ASSIGN = 2'd1,
    MODE_CHECK  = 2'd2
  } mode_e;

  // Relation codes: operand versus candidate
  typedef enum logic [REL_W-1:0] {
    REL_EQ = 3'd0,
    REL_NE = 3'd1,
    REL_GT = 3'd2,
    REL_LT = 3'd3,
    REL_GE = 3'd4,
    REL_LE = 3'd5
  } rel_e;

  // One constraint table entry; kind[3] marks a variable operand
  typedef struct packed {
    logic [VAR_W-1:0]  var_id;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] operand;
  } tbl_entry_t;

  localparam int unsigned ENTRY_W = $bits(tbl_entry_t);

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] addr;
    tbl_entry_t        entry;
  } tbl_wr_t;

  typedef struct packed {
    logic              we;
    logic [VAR_AW-1:0] addr;
    logic              set;
    logic [DATA_W-1:0] value;
  } st_wr_t;

  typedef struct packed {
    logic              re;
    logic [VAR_AW-1:0] addr;
  } st_rd_t;

  typedef struct packed {
    logic              flag;
    logic [DATA_W-1:0] value;
  } st_rsp_t;

  typedef struct packed {
    logic              start;
    logic [VAR_W-1:0]  var_id;
    logic [DATA_W-1:0] cand;
    logic [CNT_W-1:0]  count;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic result;
  } scan_rsp_t;

  // Unsigned relation test; unused codes always hold
  function automatic logic rel_holds(input logic [REL_W-1:0] rel,
                                     input logic [DATA_W-1:0] a,
                                     input logic [DATA_W-1:0] b);
    logic eq;
    logic lt;
    logic res;
    eq = (a == b);
    lt = (a < b);
    case (rel)
      REL_EQ:  res = eq;
      REL_NE:  res = !eq;
      REL_GT:  res = !eq && !lt;
      REL_LT:  res = lt;
      REL_GE:  res = !lt;
      REL_LE:  res = lt || eq;
      default: res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/csp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/csp_store.sv
// Assignment store: value RAM plus per-variable assigned flags.
`default_nettype none

module csp_store
  import csp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire st_wr_t  wr_i,
  input  wire st_rd_t  rd_i,
  output st_rsp_t      rsp_o
);

  logic [NUM_VARS-1:0] flag_q;
  logic                flag_rd_q;
  logic [DATA_W-1:0]   value_rd;

  // Assigned flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
    end else if (wr_i.we) begin
      flag_q[wr_i.addr] <= wr_i.set;
    end
  end

  // Flag read aligned with the RAM read latency
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      flag_rd_q <= flag_q[rd_i.addr];
    end
  end

  // Values; a clear leaves the stored value untouched
  csp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_VARS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.we && wr_i.set),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.value),
    .re_i    (rd_i.re),
    .raddr_i (rd_i.addr),
    .rdata_o (value_rd)
  );

  assign rsp_o.flag  = flag_rd_q;
  assign rsp_o.value = value_rd;

endmodule

`default_nettype wire

### rtl/core/csp_scan.sv
// Constraint table and the pipelined scan that checks one candidate.
`default_nettype none

module csp_scan
  import csp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tbl_wr_t   tbl_wr_i,
  input  wire scan_req_t req_i,
  output scan_rsp_t      rsp_o,
  output st_rd_t         st_rd_o,
  input  wire st_rsp_t   st_rsp_i
);

  // Stage 0: table address sequencer
  logic              issue_q;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  n_q;
  logic              zero_q;
  logic [VAR_W-1:0]  var_q;
  logic [DATA_W-1:0] cand_q;
  logic              last0;
  logic [CNT_W-1:0]  n_clamp;

  // Stage 1: entry read back
  logic              v1_q;
  logic              last1_q;
  tbl_entry_t        ent;

  // Stage 2: operand resolved, compare
  logic              v2_q;
  logic              last2_q;
  logic              match2_q;
  logic              isvar2_q;
  logic              inrange2_q;
  logic [REL_W-1:0]  rel2_q;
  logic [DATA_W-1:0] op2_q;
  logic [DATA_W-1:0] lhs;
  logic              skip;
  logic              pass;
  logic              ok_q;

  assign n_clamp = (32'(req_i.count) > MAX_CONSTRAINTS) ? CNT_W'(MAX_CONSTRAINTS)
                                                        : req_i.count;
  assign last0   = (idx_q == n_q - CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      idx_q   <= '0;
      n_q     <= '0;
      zero_q  <= 1'b0;
    end else if (req_i.start) begin
      issue_q <= (n_clamp != '0);
      idx_q   <= '0;
      n_q     <= n_clamp;
      zero_q  <= (n_clamp == '0);
    end else begin
      zero_q <= 1'b0;
      if (issue_q) begin
        idx_q <= idx_q + CNT_W'(1);
        if (last0) begin
          issue_q <= 1'b0;
        end
      end
    end
  end

  // Candidate held for the whole scan
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      var_q  <= req_i.var_id;
      cand_q <= req_i.cand;
    end
  end

  csp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CONSTRAINTS)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_wr_i.we),
    .waddr_i (tbl_wr_i.addr),
    .wdata_i (tbl_wr_i.entry),
    .re_i    (issue_q),
    .raddr_i (idx_q[TBL_AW-1:0]),
    .rdata_o (ent)
  );

  // Stage 1 valid tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
    end else begin
      v1_q    <= issue_q;
      last1_q <= issue_q && last0;
    end
  end

  // Operand variable lookup
  assign st_rd_o.re   = v1_q && ent.kind[KIND_W-1];
  assign st_rd_o.addr = ent.operand[VAR_AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      v2_q    <= v1_q;
      last2_q <= last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      match2_q   <= (ent.var_id == var_q);
      isvar2_q   <= ent.kind[KIND_W-1];
      inrange2_q <= (ent.operand[DATA_W-1:VAR_AW] == '0);
      rel2_q     <= ent.kind[REL_W-1:0];
      op2_q      <= ent.operand;
    end
  end

  // Compare and accumulate
  assign lhs  = isvar2_q ? st_rsp_i.value : op2_q;
  assign skip = !match2_q || (isvar2_q && (!inrange2_q || !st_rsp_i.flag));
  assign pass = skip || rel_holds(rel2_q, lhs, cand_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b1;
    end else if (req_i.start) begin
      ok_q <= 1'b1;
    end else if (v2_q) begin
      ok_q <= ok_q && pass;
    end
  end

  assign rsp_o.done   = (v2_q && last2_q) || zero_q;
  assign rsp_o.result = zero_q || (ok_q && pass);

endmodule

`default_nettype wire

### rtl/core/csp_constraint_checker.sv
// Top level of the constraint checker: stream ports, config register, sequencing.
//
//  channel  dir  beat when               payload
//  s_axis   in   tvalid & tready         tuser: mode; tdata: item fields
//  m_axis   out  tvalid & tready         tdata[0]: consistent
//  cfg      in   cfg_valid_i & cfg_ready_o   cfg_data_i: constraint_count
//
// Load and assign writes land at the accept edge.
// A check reads min(count,64) table entries, one per cycle, through the single
// table read port; variable operands are looked up in the store. A zero count
// answers without reading the table.
// Results pass a hold register and an output register, so an item is taken
// while a result still waits. Reset clears the assigned flags at once.
`default_nettype none

module csp_constraint_checker
  import csp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // item input
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [5:0] entry_index, [13:6] var_id, [16:14] relation, [17] operand_is_var,
  // [81:18] operand, [145:82] cand_value, [146] assign_valid, rest zero
  input  wire logic [151:0] s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]   s_axis_tuser,
  // result output
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [0] consistent, rest zero
  output logic [7:0]        m_axis_tdata,
  // configuration write
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [6:0]   cfg_data_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Item field unpacking
  logic [SLOT_W-1:0] in_slot;
  logic [VAR_W-1:0]  in_var;
  logic [REL_W-1:0]  in_rel;
  logic              in_isvar;
  logic [DATA_W-1:0] in_operand;
  logic [DATA_W-1:0] in_cand;
  logic              in_avalid;
  logic              in_beat;

  assign in_slot    = s_axis_tdata[5:0];
  assign in_var     = s_axis_tdata[13:6];
  assign in_rel     = s_axis_tdata[16:14];
  assign in_isvar   = s_axis_tdata[17];
  assign in_operand = s_axis_tdata[81:18];
  assign in_cand    = s_axis_tdata[145:82];
  assign in_avalid  = s_axis_tdata[146];

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic             hold_vld_q, hold_vld_d;
  logic             hold_res_q, hold_res_d;
  logic             out_vld_q;
  logic             out_res_q;
  logic             out_free;

  tbl_wr_t   tbl_wr;
  st_wr_t    st_wr;
  st_rd_t    st_rd;
  st_rsp_t   st_rsp;
  scan_req_t scan_req;
  scan_rsp_t scan_rsp;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !hold_vld_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Table and store writes
  assign tbl_wr.we           = in_beat && (s_axis_tuser == MODE_LOAD)
                               && (32'(in_slot) < MAX_CONSTRAINTS);
  assign tbl_wr.addr         = in_slot[TBL_AW-1:0];
  assign tbl_wr.entry.var_id = in_var;
  assign tbl_wr.entry.kind   = {in_isvar, in_rel};
  assign tbl_wr.entry.operand = in_operand;

  assign st_wr.we    = in_beat && (s_axis_tuser == MODE_ASSIGN)
                       && (32'(in_var) < NUM_VARS);
  assign st_wr.addr  = in_var[VAR_AW-1:0];
  assign st_wr.set   = in_avalid;
  assign st_wr.value = in_cand;

  assign scan_req.start  = in_beat && (s_axis_tuser == MODE_CHECK);
  assign scan_req.var_id = in_var;
  assign scan_req.cand   = in_cand;
  assign scan_req.count  = count_q;

  // Sequencer and hold register
  always_comb begin
    state_d    = state_q;
    hold_vld_d = hold_vld_q;
    hold_res_d = hold_res_q;
    if (hold_vld_q && out_free) begin
      hold_vld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (s_axis_tuser == MODE_CHECK) begin
            state_d = ST_SCAN;
          end else begin
            hold_vld_d = 1'b1;
            hold_res_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          state_d    = ST_IDLE;
          hold_vld_d = 1'b1;
          hold_res_d = scan_rsp.result;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      hold_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_res_q <= hold_res_d;
  end

  // Output register
  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= hold_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && hold_vld_q) begin
      out_res_q <= hold_res_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_res_q};

  csp_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tbl_wr_i (tbl_wr),
    .req_i    (scan_req),
    .rsp_o    (scan_rsp),
    .st_rd_o  (st_rd),
    .st_rsp_i (st_rsp)
  );

  csp_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (st_wr),
    .rd_i   (st_rd),
    .rsp_o  (st_rsp)
  );

endmodule

`default_nettype wire

### rtl/core/csp_checker.sv
// Port-level checks of the constraint checker, bound to the top level.
`default_nettype none

module csp_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [7:0]   m_axis_tdata
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pend_q;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // Items taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No result without an item taken
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result without an accepted item");

  // At most two results in flight
  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items outstanding");

  // Input stalls once both result slots are taken
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !s_axis_tready)
    else $error("item taken with no room for its result");

  // Only the low bit of the result carries data
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

endmodule

bind csp_constraint_checker csp_checker u_csp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/csp_constraint_checker_tb.sv
// Self-checking testbench for csp_constraint_checker: stream stimulus, predicted verdicts.
`timescale 1ns / 1ps

module csp_constraint_checker_tb;
  import csp_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;
  localparam logic [REL_W-1:0]  REL_RSV6  = 3'd6;
  localparam logic [REL_W-1:0]  REL_RSV7  = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_ITEMS = 160;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [VAR_W-1:0]  vid;
    logic [REL_W-1:0]  rel;
    logic              opnd_is_var;
    logic [DATA_W-1:0] opnd;
    logic [DATA_W-1:0] value;
    logic              set_flag;
  } csp_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              consistent;
  } verdict_t;

  // DUT ports
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [5:0] entry_index, [13:6] var_id, [16:14] relation, [17] operand_is_var,
  // [81:18] operand, [145:82] cand_value, [146] assign_valid, rest zero
  logic [151:0] s_axis_tdata;
  // [1:0] mode
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [0] consistent, rest zero
  logic [7:0]   m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [6:0]   cfg_data_i = '0;

  // Predicted block state
  logic [VAR_W-1:0]  tbl_var  [MAX_CONSTRAINTS];
  logic [KIND_W-1:0] tbl_kind [MAX_CONSTRAINTS];
  logic [DATA_W-1:0] tbl_opnd [MAX_CONSTRAINTS];
  logic [DATA_W-1:0] var_value [NUM_VARS];
  bit                var_set   [NUM_VARS];
  int                scan_count = 0;

  // Stimulus bookkeeping: which slots hold a loaded entry, count in force
  bit        gen_written [MAX_CONSTRAINTS];
  int        gen_count = 0;
  csp_item_t pending [$];
  csp_item_t cur_item = '0;
  verdict_t  verdicts [$];
  verdict_t  fresh;
  verdict_t  head;

  // Handshake flags and idle counters
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          src_wait = 0;
  int          src_calm = 0;
  int          sink_wait = 0;
  int          sink_calm = 0;
  int          sink_stall;
  int unsigned cycle_cnt = 0;

  // Tallies
  int err_count = 0;
  int n_loads = 0;
  int n_assigns = 0;
  int n_rsvd = 0;
  int n_true = 0;
  int n_false = 0;
  int cfg_writes = 0;

  csp_constraint_checker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  assign s_axis_tdata = {5'b0, cur_item.set_flag, cur_item.value, cur_item.opnd,
                         cur_item.opnd_is_var, cur_item.rel, cur_item.vid, cur_item.slot};
  assign s_axis_tuser = cur_item.mode;

  // Unsigned compare of operand against candidate; spare codes always hold
  function automatic logic relation_holds(input logic [REL_W-1:0] rel,
                                          input logic [DATA_W-1:0] lhs,
                                          input logic [DATA_W-1:0] rhs);
    case (rel)
      REL_EQ:  return lhs == rhs;
      REL_NE:  return lhs != rhs;
      REL_GT:  return lhs > rhs;
      REL_LT:  return lhs < rhs;
      REL_GE:  return lhs >= rhs;
      REL_LE:  return lhs <= rhs;
      default: return 1'b1;
    endcase
  endfunction

  // Update the predicted tables with one beat and return its verdict bit
  function automatic logic apply_item(input csp_item_t it);
    logic ok;
    int   n;
    ok = 1'b1;
    case (it.mode)
      MODE_LOAD: begin
        tbl_var[it.slot]  = it.vid;
        tbl_kind[it.slot] = {it.opnd_is_var, it.rel};
        tbl_opnd[it.slot] = it.opnd;
      end
      MODE_ASSIGN: begin
        var_set[it.vid] = it.set_flag;
        if (it.set_flag) var_value[it.vid] = it.value;
      end
      MODE_CHECK: begin
        n = (scan_count > MAX_CONSTRAINTS) ? MAX_CONSTRAINTS : scan_count;
        for (int i = 0; i < n && ok; i++) begin
          if (tbl_var[i] == it.vid) begin
            if (!tbl_kind[i][3]) begin
              ok = relation_holds(tbl_kind[i][2:0], tbl_opnd[i], it.value);
            end else if (tbl_opnd[i] < NUM_VARS && var_set[tbl_opnd[i][VAR_W-1:0]]) begin
              // variable operand counts only while assigned
              ok = relation_holds(tbl_kind[i][2:0], var_value[tbl_opnd[i][VAR_W-1:0]],
                                  it.value);
            end
          end
        end
      end
      default: ;
    endcase
    return ok;
  endfunction

  // Idle length: mostly none or short, some long, with calm stretches
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Values clustered near zero so relations both hold and fail, plus extremes
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return DATA_W'($urandom_range(0, 7));
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return {1'b1, 63'b0};
        default: return {{63{1'b1}}, 1'b0};
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VAR_W-1:0] pick_var();
    if ($urandom_range(0, 99) < 85) return VAR_W'($urandom_range(0, 31));
    return VAR_W'($urandom_range(0, 255));
  endfunction

  function automatic csp_item_t make_random_item();
    csp_item_t it;
    int        r;
    int        n;
    int        hole;
    it.slot        = SLOT_W'($urandom_range(0, 63));
    it.vid         = pick_var();
    it.rel         = REL_W'($urandom_range(0, 7));
    it.opnd_is_var = 1'($urandom_range(0, 1));
    it.opnd        = pick_value();
    it.value       = pick_value();
    it.set_flag    = ($urandom_range(0, 99) < 75);
    r = $urandom_range(0, 99);
    if (r < 25) it.mode = MODE_LOAD;
    else if (r < 50) it.mode = MODE_ASSIGN;
    else if (r < 95) it.mode = MODE_CHECK;
    else it.mode = MODE_RSVD;
    // a check must never scan a slot that was not loaded: fill the hole first
    if (it.mode == MODE_CHECK) begin
      n    = (gen_count > MAX_CONSTRAINTS) ? MAX_CONSTRAINTS : gen_count;
      hole = -1;
      for (int i = n - 1; i >= 0; i--) if (!gen_written[i]) hole = i;
      if (hole >= 0) begin
        it.mode = MODE_LOAD;
        it.slot = SLOT_W'(hole);
      end
    end
    if (it.mode == MODE_LOAD && it.opnd_is_var) begin
      r = $urandom_range(0, 99);
      if (r < 80) it.opnd = DATA_W'($urandom_range(0, 31));
      else if (r < 90) it.opnd = DATA_W'($urandom_range(0, 255));
    end
    return it;
  endfunction

  task automatic queue_item(input csp_item_t it);
    if (it.mode == MODE_LOAD) gen_written[it.slot] = 1'b1;
    pending.push_back(it);
  endtask

  task automatic push_item(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                           input logic [VAR_W-1:0] vid, input logic [REL_W-1:0] rel,
                           input logic isv, input logic [DATA_W-1:0] opnd,
                           input logic [DATA_W-1:0] val, input logic setf);
    csp_item_t it;
    it = '{mode: mode, slot: slot, vid: vid, rel: rel, opnd_is_var: isv,
           opnd: opnd, value: val, set_flag: setf};
    queue_item(it);
  endtask

  task automatic report_mismatch(input string what, input logic exp_bit, input logic got_bit);
    err_count++;
    if (err_count <= 30)
      $display("mismatch @%0d: %s, expected %0b got %0b", cycle_cnt, what, exp_bit, got_bit);
  endtask

  // Config write; only issued while the block is idle
  task automatic write_count(input int value);
    gen_count = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 7'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    scan_count = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending.size() != 0 || s_axis_tvalid || verdicts.size() != 0);
  endtask

  // Input driver: holds a beat until taken, then an optional gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (src_wait > 0) begin
        s_axis_tvalid <= 1'b0;
        src_wait      <= src_wait - 1;
      end else if (pending.size() != 0) begin
        cur_item      <= pending.pop_front();
        s_axis_tvalid <= 1'b1;
        src_wait      <= idle_len(src_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: stalls for a random stretch after each beat
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= sink_wait - 1;
    end else if (out_fire) begin
      sink_stall    = idle_len(sink_calm);
      m_axis_tready <= (sink_stall == 0);
      sink_wait     <= (sink_stall > 0) ? sink_stall - 1 : 0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predict on accepted inputs, compare accepted results
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      in_fire  <= s_axis_tvalid && s_axis_tready;
      out_fire <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts.size() == 0) begin
          report_mismatch("result beat with nothing pending", 1'bx, m_axis_tdata[0]);
        end else begin
          head = verdicts.pop_front();
          if (m_axis_tdata[0] !== head.consistent)
            report_mismatch("consistent", head.consistent, m_axis_tdata[0]);
          case (head.mode)
            MODE_LOAD:   n_loads++;
            MODE_ASSIGN: n_assigns++;
            MODE_CHECK:  if (head.consistent) n_true++; else n_false++;
            default:     n_rsvd++;
          endcase
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fresh.mode       = cur_item.mode;
        fresh.consistent = apply_item(cur_item);
        verdicts.push_back(fresh);
      end
    end
  end

  // Test sequence
  initial begin
    int phase_count [RAND_PHASES];
    phase_count = '{64, 1, 127, 7, 65, 0, 33, 0};
    phase_count[RAND_PHASES-1] = $urandom_range(0, 127);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty scan: checks pass trivially; a spare-mode beat, then one entry per relation and per spare code
    write_count(0);
    push_item(MODE_CHECK, 6'd0, 8'd0, REL_EQ, 1'b0, '0, '0, 1'b0);
    push_item(MODE_RSVD, '1, '1, '1, 1'b1, '1, '1, 1'b1);
    push_item(MODE_LOAD, 6'd0, 8'd1, REL_EQ, 1'b0, 64'd5, '0, 1'b0);
    push_item(MODE_LOAD, 6'd1, 8'd2, REL_NE, 1'b0, 64'd5, '0, 1'b0);
    push_item(MODE_LOAD, 6'd2, 8'd3, REL_GT, 1'b0, 64'd5, '0, 1'b0);
    push_item(MODE_LOAD, 6'd3, 8'd4, REL_LT, 1'b0, 64'd5, '0, 1'b0);
    push_item(MODE_LOAD, 6'd4, 8'd5, REL_GE, 1'b0, 64'd5, '0, 1'b0);
    push_item(MODE_LOAD, 6'd5, 8'd6, REL_LE, 1'b0, 64'd5, '0, 1'b0);
    push_item(MODE_LOAD, 6'd6, 8'd7, REL_RSV6, 1'b0, '0, '0, 1'b0);
    push_item(MODE_LOAD, 6'd7, 8'd8, REL_RSV7, 1'b0, '1, '0, 1'b0);
    // variable operands: one in the store, one past its end
    push_item(MODE_LOAD, 6'd8, 8'd9, REL_EQ, 1'b1, 64'd200, '0, 1'b0);
    push_item(MODE_LOAD, 6'd9, 8'd9, REL_LT, 1'b1, '1, '0, 1'b0);
    push_item(MODE_ASSIGN, '0, 8'd200, REL_EQ, 1'b0, '0, 64'd7, 1'b1);
    push_item(MODE_ASSIGN, '0, 8'd255, REL_EQ, 1'b0, '0, '1, 1'b1);
    wait_idle();

    // Each relation at its boundary, then the variable-operand cases
    write_count(10);
    for (int v = 1; v <= 8; v++)
      push_item(MODE_CHECK, '0, VAR_W'(v), REL_EQ, 1'b0, '0, 64'd5, 1'b0);
    push_item(MODE_CHECK, '0, 8'd3, REL_EQ, 1'b0, '0, 64'd4, 1'b0);
    push_item(MODE_CHECK, '0, 8'd9, REL_EQ, 1'b0, '0, 64'd7, 1'b0);
    push_item(MODE_CHECK, '0, 8'd9, REL_EQ, 1'b0, '0, 64'd8, 1'b0);
    push_item(MODE_ASSIGN, '0, 8'd200, REL_EQ, 1'b0, '0, '0, 1'b0);
    push_item(MODE_CHECK, '0, 8'd9, REL_EQ, 1'b0, '0, 64'd8, 1'b0);
    wait_idle();

    // Random phases over a range of scan counts
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_count(phase_count[p]);
      repeat (PHASE_ITEMS) queue_item(make_random_item());
      wait_idle();
    end

    repeat (100) @(posedge clk_i);
    while (verdicts.size() != 0) begin
      head = verdicts.pop_front();
      report_mismatch("result never arrived", head.consistent, 1'bx);
    end

    $display("run covered %0d loads, %0d assignments, %0d spare-mode beats, %0d checks",
             n_loads, n_assigns, n_rsvd, n_true + n_false);
    $display("checks: %0d consistent, %0d violated; %0d scan counts set; %0d mismatches",
             n_true, n_false, cfg_writes, err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/csp_pkg.sv
rtl/core/csp_ram.sv
rtl/core/csp_store.sv
rtl/core/csp_scan.sv
rtl/core/csp_constraint_checker.sv
rtl/core/csp_checker.sv
tb/csp_constraint_checker_tb.sv
